[hdl/jsr_pkg.sv]
// ----------------------------------------------------------------------------
// jsr_pkg: shared types and constants for the Jacobi stencil sweep
// Field widths, register indexes, reset values and the pipeline tag.
// ----------------------------------------------------------------------------
package jsr_pkg;

    // fixed field widths
    localparam int DATA_W   = 32;    // Q16.16 samples and results
    localparam int CFG_W    = 11;    // width of the size registers
    localparam int POS_W    = 10;    // point_row / point_col
    localparam int RES_W    = 64;    // Q32.32 residual
    localparam int RESULT_W = DATA_W + 2 * POS_W + RES_W;
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // sizes
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 1024;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] GRID_RESET = 11'd256;

    // bookkeeping that travels with each accepted sample
    typedef struct packed {
        logic             prod;   // sample completes an interior point
        logic             clr;    // first sample of a frame
        logic             last;   // final interior point of the frame
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } tag_t;

endpackage

[hdl/jacobi_stencil_relaxation_top.sv]
// ----------------------------------------------------------------------------
// jacobi_stencil_relaxation_top: one Jacobi five-point sweep over a stream
// Raster-ordered Q16.16 samples in, relaxed interior points out, with a
// saturating running sum of squared changes per frame.
// ----------------------------------------------------------------------------
//
//  channel  | ports                        | payload (low bit first)
//  ---------+------------------------------+--------------------------------------
//  input    | s_tvalid s_tready s_tdata    | sample[31:0]
//  result   | m_tvalid m_tready m_tdata    | new_value, point_row, point_col,
//           | m_tlast                      |   residual, zero pad; tlast=last_point
//  config   | cfg_we cfg_addr cfg_wdata    | 0: grid_width, 1: grid_height
//
//  One sample per cycle while the output is not stalled; the middle store takes two reads
//  and one write request per accepted sample, the upper store one read and one write.
//  A result passes stage 1 to stage 4 and the output register before m_tvalid shows it.
//  Reset clears counters, residual and pipeline valids; row stores hold
//  garbage until written, so there is no clearing pass.
//  Stalls on m_tready back up stage by stage; bubbles collapse.
//
module jacobi_stencil_relaxation_top
    import jsr_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input samples
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,    // sample[31:0]
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,    // new_value[31:0], point_row[41:32],
                                              // point_col[51:42], residual[115:52]
    output logic                  m_tlast,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > CFG_W) ? WW : CFG_W;
    localparam int PAD_W = TDATA_W - RESULT_W;

    // ------------------------------------------------------------------
    // configuration registers
    logic [CFG_W-1:0] gw_reg, gh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg <= GRID_RESET;
            gh_reg <= GRID_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_GRID_WIDTH:  gw_reg <= cfg_wdata;
                REG_GRID_HEIGHT: gh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, oversize clamps
    logic [EW-1:0]    w_eff;
    logic [CFG_W-1:0] h_eff;

    always_comb begin
        if (gw_reg == '0) begin
            w_eff = EW'(1);
        end else if (EW'(gw_reg) > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(gw_reg);
        end
        if (gh_reg == '0) begin
            h_eff = CFG_W'(1);
        end else if (gh_reg > CFG_W'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = gh_reg;
        end
    end

    // ------------------------------------------------------------------
    // pipeline handshake, computed from the output back
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, o_v_reg;
    logic o_free, s4_go, s4_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;
    logic acc_in;

    assign o_free  = !o_v_reg || m_tready;
    assign s4_go   = s4_v_reg && o_free;
    assign s4_free = !s4_v_reg || s4_go;
    assign s3_go   = s3_v_reg && s4_free;
    assign s3_free = !s3_v_reg || s3_go;
    assign s2_go   = s2_v_reg && s3_free;
    assign s2_free = !s2_v_reg || s2_go;
    assign s1_go   = s1_v_reg && s2_free;
    assign s1_free = !s1_v_reg || s1_go;

    assign s_tready = s1_free;
    assign acc_in   = s_tvalid && s1_free;

    // ------------------------------------------------------------------
    // raster position and what the incoming sample completes
    logic [CW-1:0]    col_reg, col_next, col_nx;
    logic [POS_W-1:0] row_reg, row_next;
    logic [EW-1:0]    c_ext;
    logic [CFG_W-1:0] r_ext;
    logic             row_end, produce, is_last;
    tag_t             in_tag;

    assign c_ext  = EW'(col_reg);
    assign r_ext  = CFG_W'(row_reg);
    assign col_nx = col_reg + CW'(1);

    assign row_end = c_ext >= (w_eff - EW'(1));
    assign produce = (w_eff >= EW'(3)) && (h_eff >= CFG_W'(3))
                  && (row_reg >= POS_W'(2)) && (r_ext <= h_eff - CFG_W'(1))
                  && (col_reg != '0) && (c_ext <= w_eff - EW'(2));
    assign is_last = (r_ext == h_eff - CFG_W'(1)) && (c_ext == w_eff - EW'(2));

    always_comb begin
        in_tag.prod = produce;
        in_tag.clr  = (row_reg == '0) && (col_reg == '0);
        in_tag.last = is_last;
        in_tag.row  = row_reg - POS_W'(1);
        in_tag.col  = POS_W'(col_reg);
    end

    // column wraps at width-1, row wraps at height-1
    always_comb begin
        if (row_end) begin
            col_next = '0;
            row_next = (r_ext >= h_eff - CFG_W'(1)) ? '0 : row_reg + POS_W'(1);
        end else begin
            col_next = col_nx;
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (acc_in) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // row stores: middle holds row r-1, upper row r-2, ahead of the column
    logic [DATA_W-1:0] mid_mem [MAX_WIDTH];
    logic [DATA_W-1:0] up_mem  [MAX_WIDTH];
    logic [DATA_W-1:0] mid_c_rd, mid_r_rd, up_rd;
    logic [CW-1:0]     s1_col_reg;

    // middle: sample written, centre and right neighbour read (old data)
    always_ff @(posedge aclk) begin
        if (acc_in) begin
            mid_mem[col_reg] <= s_tdata;
            mid_c_rd         <= mid_mem[col_reg];
            mid_r_rd         <= mid_mem[col_nx];
        end
    end

    // upper: top read on request, old centre written as the item leaves s1
    always_ff @(posedge aclk) begin
        if (acc_in) begin
            up_rd <= up_mem[col_reg];
        end
        if (s1_go) begin
            up_mem[s1_col_reg] <= mid_c_rd;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: operands ready, sum of four neighbours
    tag_t              s1_tag;
    logic [DATA_W-1:0] s1_smp, s1_fwd_data, left_reg, top_val;
    logic              s1_fwd;
    logic [DATA_W+1:0] nb_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (acc_in) begin
            s1_v_reg <= 1'b1;
        end else if (s1_go) begin
            s1_v_reg <= 1'b0;
        end
    end

    // same-column upper write in the accept cycle: forward the write data
    always_ff @(posedge aclk) begin
        if (acc_in) begin
            s1_tag      <= in_tag;
            s1_smp      <= s_tdata;
            s1_col_reg  <= col_reg;
            s1_fwd      <= s1_go && (s1_col_reg == col_reg);
            s1_fwd_data <= mid_c_rd;
        end
        if (s1_go) begin
            left_reg <= mid_c_rd;
        end
    end

    assign top_val = s1_fwd ? s1_fwd_data : up_rd;
    assign nb_sum  = {{2{left_reg[DATA_W-1]}}, left_reg}
                   + {{2{mid_r_rd[DATA_W-1]}}, mid_r_rd}
                   + {{2{top_val[DATA_W-1]}},  top_val}
                   + {{2{s1_smp[DATA_W-1]}},   s1_smp};

    // ------------------------------------------------------------------
    // stage 2: new value known, change against old centre
    tag_t              s2_tag;
    logic [DATA_W-1:0] s2_nv, s2_ctr;
    logic [DATA_W:0]   diff, diff_abs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (s1_go) begin
            s2_v_reg <= 1'b1;
        end else if (s2_go) begin
            s2_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            s2_tag <= s1_tag;
            s2_nv  <= nb_sum[DATA_W+1:2];     // arithmetic shift by two
            s2_ctr <= mid_c_rd;
        end
    end

    assign diff     = {s2_nv[DATA_W-1], s2_nv} - {s2_ctr[DATA_W-1], s2_ctr};
    assign diff_abs = diff[DATA_W] ? (~diff + (DATA_W+1)'(1)) : diff;

    // ------------------------------------------------------------------
    // stage 3: square of the change, saturated when it cannot fit
    tag_t              s3_tag;
    logic [DATA_W-1:0] s3_nv, s3_ad;
    logic              s3_big;
    logic [RES_W-1:0]  sq_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_v_reg <= 1'b0;
        end else if (s2_go) begin
            s3_v_reg <= 1'b1;
        end else if (s3_go) begin
            s3_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_go) begin
            s3_tag <= s2_tag;
            s3_nv  <= s2_nv;
            s3_ad  <= diff_abs[DATA_W-1:0];
            s3_big <= diff_abs[DATA_W];
        end
    end

    assign sq_val = s3_big ? '1 : RES_W'(s3_ad) * RES_W'(s3_ad);

    // ------------------------------------------------------------------
    // stage 4: saturating accumulate into the frame residual
    tag_t              s4_tag;
    logic [DATA_W-1:0] s4_nv;
    logic [RES_W-1:0]  s4_sq, acc_reg, acc_sat;
    logic [RES_W:0]    acc_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_v_reg <= 1'b0;
        end else if (s3_go) begin
            s4_v_reg <= 1'b1;
        end else if (s4_go) begin
            s4_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_go) begin
            s4_tag <= s3_tag;
            s4_nv  <= s3_nv;
            s4_sq  <= sq_val;
        end
    end

    assign acc_sum = {1'b0, acc_reg} + {1'b0, s4_sq};
    assign acc_sat = acc_sum[RES_W] ? '1 : acc_sum[RES_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (s4_go) begin
            if (s4_tag.clr) begin
                acc_reg <= '0;
            end else if (s4_tag.prod) begin
                acc_reg <= acc_sat;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    logic [DATA_W-1:0] o_nv;
    logic [POS_W-1:0]  o_row, o_col;
    logic [RES_W-1:0]  o_res;
    logic              o_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_v_reg <= 1'b0;
        end else if (s4_go) begin
            o_v_reg <= s4_tag.prod;
        end else if (m_tready) begin
            o_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_go && s4_tag.prod) begin
            o_nv   <= s4_nv;
            o_row  <= s4_tag.row;
            o_col  <= s4_tag.col;
            o_res  <= acc_sat;
            o_last <= s4_tag.last;
        end
    end

    assign m_tvalid = o_v_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, o_res, o_col, o_row, o_nv};
    assign m_tlast  = o_last;

`ifndef SYNTHESIS
    // read data must survive while stage 1 waits (unwritten entries read as X)
    a_rd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_v_reg && !s1_go |=> (mid_c_rd === $past(mid_c_rd))
                            && (mid_r_rd === $past(mid_r_rd))
                            && (up_rd === $past(up_rd)))
        else $error("row store read data changed under a stalled stage 1");

    // accumulation never decreases within a frame
    a_res_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_go && s4_tag.prod |=> acc_reg >= $past(acc_reg))
        else $error("residual decreased");

    // frame start clears the residual
    a_res_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_go && s4_tag.clr |=> acc_reg == '0)
        else $error("residual not cleared at frame start");

    // only interior points leave the block
    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        o_v_reg |-> (o_row != '0) && (o_col != '0))
        else $error("boundary point emitted");
`endif

endmodule

[tb/jsr_checker.sv]
// ----------------------------------------------------------------------------
// jsr_checker: scoreboard for the Jacobi five-point stencil sweep
// Watches the sample, result and register ports, keeps its own copy of
// the row stores, raster counters and residual, and checks every result.
// ----------------------------------------------------------------------------
module jsr_checker
    import jsr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,    // sample[31:0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_W-1:0]    m_tdata,    // new_value, point_row, point_col, residual
    input  logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output int                    fail_count,
    output int                    pending,
    output int                    points_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = DEF_MAX_WIDTH;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [DATA_W-1:0] new_value;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [RES_W-1:0]  residual;
        logic              last;
    } relaxed_point_t;

    relaxed_point_t     expected_points[$];

    // shadow of the block state
    logic signed [DATA_W-1:0] upper_row [STORE_DEPTH];
    logic signed [DATA_W-1:0] middle_row [STORE_DEPTH];
    logic [CFG_W-1:0]         width_reg;
    logic [CFG_W-1:0]         height_reg;
    int                       row_pos;
    int                       col_pos;
    logic [RES_W-1:0]         residual_sum;

    int mismatches = 0;
    int checked = 0;

    // register value to effective size: 0 acts as 1, above cap acts as cap
    function automatic int size_eff(logic [CFG_W-1:0] v, int cap);
        if (v == 0) return 1;
        if (int'(v) > cap) return cap;
        return int'(v);
    endfunction

    function automatic void check_field(string name, logic [RES_W-1:0] want,
                                        logic [RES_W-1:0] seen);
        if (seen !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
        end
    endfunction

    // one raster sample: relax the point above it when interior, then shift stores
    task automatic relax_sample(input logic signed [DATA_W-1:0] smp);
        int             w;
        int             h;
        int             r;
        int             c;
        longint         sum4;
        longint         relaxed;
        longint         delta;
        logic [63:0]    mag;
        logic [63:0]    square;
        logic [63:0]    total;
        relaxed_point_t pt;

        w = size_eff(width_reg, STORE_DEPTH);
        h = size_eff(height_reg, MAX_HEIGHT);
        r = row_pos;
        c = col_pos;

        // frame start clears the running residual
        if (r == 0 && c == 0) residual_sum = '0;

        if (w >= 3 && h >= 3 && r >= 2 && r <= h - 1 && c >= 1 && c <= w - 2
                && c + 1 < STORE_DEPTH) begin
            // west was already moved into the upper store on the previous sample
            sum4 = longint'(upper_row[c-1]) + longint'(middle_row[c+1])
                 + longint'(upper_row[c]) + longint'(smp);
            relaxed = sum4 >>> 2;
            delta = relaxed - longint'(middle_row[c]);
            if (delta < 0) delta = -delta;
            mag = delta;
            square = (mag >= 64'h1_0000_0000) ? '1 : mag * mag;
            total = residual_sum + square;
            if (total < residual_sum) total = '1;
            residual_sum = total;

            pt.new_value = relaxed[DATA_W-1:0];
            pt.row       = POS_W'(r - 1);
            pt.col       = POS_W'(c);
            pt.residual  = residual_sum;
            pt.last      = (r == h - 1 && c == w - 2);
            expected_points.push_back(pt);
        end

        if (c < STORE_DEPTH) begin
            upper_row[c]  = middle_row[c];
            middle_row[c] = smp;
        end

        // raster advance, wrapping at or beyond the current edges
        if (c >= w - 1) begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge aclk) begin
        relaxed_point_t got;
        relaxed_point_t want;

        if (!aresetn) begin
            width_reg    = GRID_RESET;
            height_reg   = GRID_RESET;
            row_pos      = 0;
            col_pos      = 0;
            residual_sum = '0;
            expected_points.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_addr)
                    REG_GRID_WIDTH:  width_reg = cfg_wdata;
                    REG_GRID_HEIGHT: height_reg = cfg_wdata;
                    default: ;
                endcase
            end

            // result requests against the oldest expectation
            if (m_tvalid && m_tready) begin
                got.new_value = m_tdata[0 +: DATA_W];
                got.row       = m_tdata[DATA_W +: POS_W];
                got.col       = m_tdata[DATA_W + POS_W +: POS_W];
                got.residual  = m_tdata[DATA_W + 2 * POS_W +: RES_W];
                got.last      = m_tlast;
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with no expectation, expected none, got %0h",
                                 $time, got);
                end else begin
                    want = expected_points.pop_front();
                    checked++;
                    check_field("new_value", want.new_value, got.new_value);
                    check_field("point_row", want.row, got.row);
                    check_field("point_col", want.col, got.col);
                    check_field("residual", want.residual, got.residual);
                    check_field("last_point", want.last, got.last);
                end
            end

            // sample requests
            if (s_tvalid && s_tready) relax_sample(s_tdata);
        end

        fail_count     <= mismatches;
        pending        <= expected_points.size();
        points_checked <= checked;
    end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the Jacobi stencil sweep
// Streams grids of several sizes (reset default, directed rounding and
// saturation frames, a mid-size frame with no idling, oversized and
// degenerate sizes, random frames and partial frames with size changes
// mid-frame) under random idling on both channels; the checker scores
// every result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsr_pkg::*;

    typedef enum int {VAL_SMALL, VAL_FULL, VAL_EXTREME} sample_range_t;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
    localparam int RANDOM_SAMPLES = 510;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire                   m_tlast;
    wire [TDATA_W-1:0]     m_tdata;

    int            fail_count;
    int            pending;
    int            points_checked;

    // stimulus bookkeeping: effective grid size and raster position
    bit            calm = 1'b0;
    sample_range_t value_mode = VAL_SMALL;
    int            grid_w = 256;
    int            grid_h = 256;
    int            pos_r = 0;
    int            pos_c = 0;
    int            samples_sent = 0;
    int            settings_used = 0;

    jacobi_stencil_relaxation_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    jsr_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .points_checked (points_checked)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 12);
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int size_eff(int v, int cap);
        if (v == 0) return 1;
        if (v > cap) return cap;
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] pick_sample(sample_range_t mode);
        case (mode)
            VAL_SMALL: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            VAL_FULL:  return $urandom();
            default: begin
                case ($urandom_range(4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return '1;
                    default: return $urandom();
                endcase
            end
        endcase
    endfunction

    function automatic int pick_width();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return $urandom_range(0, 2);
        if (roll < 25) return $urandom_range(13, 40);
        return $urandom_range(3, 12);
    endfunction

    function automatic int pick_height();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) return $urandom_range(0, 2);
        if (roll < 30) return $urandom_range(9, 24);
        return $urandom_range(3, 8);
    endfunction

    // one sample request; called and returns at a falling edge
    task automatic send_sample(input logic [DATA_W-1:0] v);
        while (!calm && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        samples_sent++;
        if (pos_c >= grid_w - 1) begin
            pos_c = 0;
            pos_r = (pos_r >= grid_h - 1) ? 0 : pos_r + 1;
        end else begin
            pos_c++;
        end
    endtask

    task automatic send_random();
        send_sample(pick_sample(value_mode));
    endtask

    // runs to the next frame start (a whole frame when already at one)
    task automatic finish_frame();
        do send_random(); while (pos_r != 0 || pos_c != 0);
    endtask

    // hold the sender until every expected result is back and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    // both sizes back to back; width is to grow only at frame starts, unchecked
    task automatic set_grid(input int w, input int h);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_GRID_WIDTH;
        cfg_wdata <= CFG_W'(w);
        @(negedge aclk);
        cfg_addr  <= REG_GRID_HEIGHT;
        cfg_wdata <= CFG_W'(h);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
        grid_w = size_eff(w, DEF_MAX_WIDTH);
        grid_h = size_eff(h, MAX_HEIGHT);
        settings_used++;
    endtask

    initial begin
        int base;
        int new_w;
        int new_h;
        int wait_cycles;
        int left_over;
        int frame_size;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // reset sizes: two full rows and part of the third, then shrink mid-frame
        repeat (600) send_random();
        drain();
        set_grid(3, 3);
        while (pos_r != 0 || pos_c != 0) send_random();

        // rounding toward minus infinity: one neighbor at -1, the rest zero
        for (int i = 0; i < 9; i++) send_sample((i == 3) ? '1 : '0);
        drain();

        // checkerboard of extremes: each square near 2^64, the sum saturates
        set_grid(4, 3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
                send_sample(((r + c) % 2 == 0) ? Q_MAX : Q_MIN);
        drain();

        // mid-size grid, no idling on either side
        set_grid(40, 6);
        calm = 1'b1;
        finish_frame();
        drain();
        calm = 1'b0;

        // oversized height clamps; full-range data over the first rows
        set_grid(3, 2047);
        value_mode = VAL_FULL;
        repeat (150) send_random();
        drain();

        // oversized width, then degenerate sizes with a mid-frame shrink
        set_grid(2047, 1);
        repeat (300) send_random();
        drain();
        set_grid(2, 0);
        repeat (20) send_random();
        drain();
        set_grid(0, 2);
        repeat (10) send_random();

        // random settings with whole and partial frames, within the sample budget
        base = samples_sent;
        while (samples_sent - base < RANDOM_SAMPLES) begin
            drain();
            if (pos_r == 0 && pos_c == 0) new_w = pick_width();
            else new_w = $urandom_range(0, grid_w);
            new_h = pick_height();
            set_grid(new_w, new_h);
            case ($urandom_range(9))
                0, 1: value_mode = VAL_FULL;
                2: value_mode = VAL_EXTREME;
                default: value_mode = VAL_SMALL;
            endcase
            calm = (settings_used % 9 == 4);
            left_over  = RANDOM_SAMPLES - (samples_sent - base);
            frame_size = grid_w * grid_h;
            if (frame_size <= left_over && $urandom_range(99) < 65) finish_frame();
            else repeat ($urandom_range(1, (frame_size < left_over) ? frame_size : left_over))
                send_random();
        end
        calm = 1'b0;

        // let the last results out, with a bound
        s_tvalid <= 1'b0;
        for (wait_cycles = 0; pending != 0 && wait_cycles < 100000; wait_cycles++)
            @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("Streamed %0d samples under %0d grid settings (reset, tiny, oversized, random).",
                 samples_sent, settings_used);
        $display("Compared %0d relaxed points; %0d field errors, %0d still outstanding.",
                 points_checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
